// ===== design/gcn_pkg.sv =====
// Package for the graph-convolution layer: sizes, function codes and fixed-point helpers.
// Used by the top level and the multiplier; depends on nothing.
package gcn_pkg;
    localparam int MaxNodes = 1024;
    localparam int MaxEdges = 8192;
    localparam int InFeat   = 16;
    localparam int OutFeat  = 16;
    localparam int NodeW    = $clog2(MaxNodes);
    localparam int EdgeW    = $clog2(MaxEdges);
    localparam int InW      = $clog2(InFeat);
    localparam int OutW     = $clog2(OutFeat);
    localparam int EdgeCntW = EdgeW + 1;

    typedef enum logic [3:0] {
        FN_FEATURE  = 4'd0,
        FN_SCALE    = 4'd1,
        FN_ROWSTART = 4'd2,
        FN_COLUMN   = 4'd3,
        FN_WEIGHT   = 4'd4,
        FN_BIAS     = 4'd5,
        FN_COMPUTE  = 4'd6,
        FN_RD_PROJ  = 4'd7,
        FN_RD_SCALE = 4'd8
    } t_func;

    localparam logic [1:0] REG_NUM_NODES = 2'd0;
    localparam logic [1:0] REG_IN_FEAT   = 2'd1;
    localparam logic [1:0] REG_OUT_FEAT  = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        return sat32(s);
    endfunction

    // Rounds a registered 64-bit product to Q16.16 with saturation.
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [64:0] t;
        logic signed [48:0] q;
        logic signed [31:0] r;
        t = 65'(p) + 65'sd32768;
        q = t[64:16];
        if (q > 49'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (q < -49'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction
endpackage

// ===== design/gcn_layer_forward_csr.sv =====
// Top level of the graph-convolution layer with its stores and sequencer.
// Depends on gcn_pkg and gcn_mac.
//
// Items arrive on the input channel (i_valid, o_stall); results leave on the
// output channel (o_valid, i_stall). Loads write one store word and give no
// result. Reads of projected or scaled values give one result, through the
// states S_RD and S_RD2. A compute item runs the whole layer out of the
// synchronous stores, reading them word by word through one registered
// multiplier, and gives one status beat when it ends. It runs scaling,
// then per node aggregation and projection; each step waits for its memory
// read and the multiplier. While a result waits for the receiver the block
// stalls its input, so a stalled receiver holds back further items without
// loss. Reset clears the sequencer, the result valid flag, the error flag and
// restores the registers num_nodes=1, in_features=16, out_features=16.
// Stores are not cleared.
module gcn_layer_forward_csr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_func,
    input  logic [13:0]        i_index,
    input  logic [3:0]         i_sub_index,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic signed [31:0] o_value_res
);
    localparam int FW = gcn_pkg::NodeW + gcn_pkg::InW;
    localparam int PW = gcn_pkg::NodeW + gcn_pkg::OutW;
    localparam int WW = gcn_pkg::InW + gcn_pkg::OutW;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RD2, S_SC_A, S_SC_B, S_SC_M, S_SC_W,
        S_AG_RS, S_AG_RS2, S_AG_SELF, S_AG_SELF2, S_AG_E, S_AG_E2, S_AG_NB, S_AG_NB2,
        S_PJ_K, S_PJ_K2, S_PJ_M, S_PJ_ACC, S_PJ_S, S_PJ_S2, S_PJ_B, S_NEXT, S_DONE
    } t_state;

    logic signed [31:0] m_feat  [gcn_pkg::MaxNodes*gcn_pkg::InFeat];
    logic signed [31:0] m_scale [gcn_pkg::MaxNodes];
    logic [gcn_pkg::EdgeCntW-1:0] m_rs [gcn_pkg::MaxNodes+1];
    logic [31:0]        m_col   [gcn_pkg::MaxEdges];
    logic signed [31:0] m_wt    [gcn_pkg::InFeat*gcn_pkg::OutFeat];
    logic signed [31:0] m_bias  [gcn_pkg::OutFeat];
    logic signed [31:0] m_scd   [gcn_pkg::MaxNodes*gcn_pkg::InFeat];
    logic signed [31:0] m_proj  [gcn_pkg::MaxNodes*gcn_pkg::OutFeat];
    logic signed [31:0] r_agg   [gcn_pkg::InFeat];

    t_state r_state;
    logic [10:0] r_nn;
    logic [4:0]  r_fi, r_fo;
    logic [10:0] n_eff;
    logic [4:0]  fi_eff, fo_eff;
    logic r_err, r_ovalid;
    logic signed [31:0] r_ores;
    logic r_rdsel, r_rdok;

    logic [gcn_pkg::NodeW:0] r_i;
    logic [4:0] r_q, r_o;
    logic [gcn_pkg::EdgeCntW-1:0] r_e, r_eend;
    logic [gcn_pkg::NodeW-1:0] r_j;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_ma, r_mb;
    logic signed [31:0] mq;

    logic signed [31:0] rd_feat, rd_scale, rd_wt, rd_bias, rd_scd, rd_proj;
    logic [gcn_pkg::EdgeCntW-1:0] rd_rs;
    logic [31:0] rd_col;

    logic [gcn_pkg::NodeW-1:0] ii;
    logic [gcn_pkg::InW-1:0] qq;
    logic [gcn_pkg::OutW-1:0] oo;
    logic acc_in;
    logic [33:0] rs_clamp;

    assign n_eff  = (r_nn > 11'(gcn_pkg::MaxNodes)) ? 11'(gcn_pkg::MaxNodes) : r_nn;
    assign fi_eff = (r_fi > 5'(gcn_pkg::InFeat)) ? 5'(gcn_pkg::InFeat) : r_fi;
    assign fo_eff = (r_fo > 5'(gcn_pkg::OutFeat)) ? 5'(gcn_pkg::OutFeat) : r_fo;
    assign ii = r_i[gcn_pkg::NodeW-1:0];
    assign qq = r_q[gcn_pkg::InW-1:0];
    assign oo = r_o[gcn_pkg::OutW-1:0];

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign acc_in  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_value_res = r_ores;
    assign o_status = r_err;

    gcn_mac u_mac (.i_clk(i_clk), .i_a(r_ma), .i_b(r_mb), .o_q(mq));

    always_comb begin
        if (i_value < 0) begin
            rs_clamp = '0;
        end else if (i_value > 32'sd8192) begin
            rs_clamp = 34'(gcn_pkg::MaxEdges);
        end else begin
            rs_clamp = 34'(i_value);
        end
    end

    // Store writes from load items and from the compute sequence.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            unique case (i_func)
                gcn_pkg::FN_FEATURE:
                    if (i_index < 14'(gcn_pkg::MaxNodes))
                        m_feat[{i_index[gcn_pkg::NodeW-1:0], i_sub_index}] <= i_value;
                gcn_pkg::FN_SCALE:
                    if (i_index < 14'(gcn_pkg::MaxNodes))
                        m_scale[i_index[gcn_pkg::NodeW-1:0]] <= i_value;
                gcn_pkg::FN_ROWSTART:
                    if (i_index <= 14'(gcn_pkg::MaxNodes))
                        m_rs[i_index[gcn_pkg::NodeW:0]] <= rs_clamp[gcn_pkg::EdgeCntW-1:0];
                gcn_pkg::FN_COLUMN:
                    if (i_index < 14'(gcn_pkg::MaxEdges))
                        m_col[i_index[gcn_pkg::EdgeW-1:0]] <= i_value;
                gcn_pkg::FN_WEIGHT:
                    if (i_index < 14'(gcn_pkg::InFeat))
                        m_wt[{i_index[gcn_pkg::InW-1:0], i_sub_index}] <= i_value;
                gcn_pkg::FN_BIAS:
                    m_bias[i_sub_index] <= i_value;
                default: ;
            endcase
        end
        if (r_state == S_SC_W) m_scd[FW'({ii, qq})] <= mq;
        if (r_state == S_PJ_B) m_proj[PW'({ii, oo})] <= gcn_pkg::sadd(mq, rd_bias);
    end

    // Registered reads; addresses follow the sequencer or the read item.
    always_ff @(posedge i_clk) begin
        rd_feat  <= m_feat[FW'({ii, qq})];
        rd_scale <= m_scale[ii];
        rd_rs    <= m_rs[(r_state == S_AG_RS) ? r_i : r_i + 1'b1];
        rd_col   <= m_col[r_e[gcn_pkg::EdgeW-1:0]];
        rd_wt    <= m_wt[WW'({qq, oo})];
        rd_bias  <= m_bias[oo];
        if (r_state == S_IDLE) begin
            rd_scd  <= m_scd[FW'({i_index[gcn_pkg::NodeW-1:0], i_sub_index})];
            rd_proj <= m_proj[PW'({i_index[gcn_pkg::NodeW-1:0], i_sub_index})];
        end else if (r_state == S_AG_NB) begin
            rd_scd  <= m_scd[FW'({r_j, qq})];
        end else if (r_state != S_RD) begin
            rd_scd  <= m_scd[FW'({ii, qq})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nn     <= 11'd1;
            r_fi     <= 5'd16;
            r_fo     <= 5'd16;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gcn_pkg::REG_NUM_NODES: r_nn <= i_cfg_data;
                    gcn_pkg::REG_IN_FEAT:   r_fi <= i_cfg_data[4:0];
                    gcn_pkg::REG_OUT_FEAT:  r_fo <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_rdsel <= (i_func == gcn_pkg::FN_RD_PROJ);
                        r_rdok  <= (i_index < 14'(gcn_pkg::MaxNodes));
                        if (i_func == gcn_pkg::FN_COMPUTE) begin
                            r_err <= 1'b0;
                            r_i <= '0;
                            r_q <= '0;
                            r_state <= S_SC_A;
                        end else if (i_func == gcn_pkg::FN_RD_PROJ ||
                                     i_func == gcn_pkg::FN_RD_SCALE) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_RD2;
                S_RD2: begin
                    r_ores   <= r_rdok ? (r_rdsel ? rd_proj : rd_scd) : 32'sd0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_SC_A: begin
                    if (r_i >= n_eff) begin
                        r_i <= '0;
                        r_state <= S_AG_RS;
                    end else if (r_q >= fi_eff) begin
                        r_q <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_SC_B;
                    end
                end
                S_SC_B: begin
                    r_ma <= rd_scale;
                    r_mb <= rd_feat;
                    r_state <= S_SC_M;
                end
                S_SC_M: r_state <= S_SC_W;
                S_SC_W: begin
                    r_q <= r_q + 1'b1;
                    r_state <= S_SC_A;
                end
                S_AG_RS: begin
                    if (r_i >= n_eff) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_AG_RS2;
                    end
                end
                S_AG_RS2: begin
                    r_e <= rd_rs;
                    r_q <= '0;
                    r_state <= S_AG_SELF;
                end
                S_AG_SELF: begin
                    r_eend <= rd_rs;
                    if (r_q >= fi_eff) begin
                        r_state <= S_AG_E;
                    end else begin
                        r_state <= S_AG_SELF2;
                    end
                end
                S_AG_SELF2: begin
                    r_agg[qq] <= rd_scd;
                    r_q <= r_q + 1'b1;
                    r_state <= S_AG_SELF;
                end
                S_AG_E: begin
                    if (r_e >= r_eend || r_e >= gcn_pkg::EdgeCntW'(gcn_pkg::MaxEdges)) begin
                        r_o <= '0;
                        r_state <= S_PJ_K;
                        r_q <= '0;
                        r_acc <= '0;
                    end else begin
                        r_state <= S_AG_E2;
                    end
                end
                S_AG_E2: begin
                    r_e <= r_e + 1'b1;
                    r_q <= '0;
                    if ($signed(rd_col) < 0 || rd_col >= 32'(n_eff)) begin
                        r_err <= 1'b1;
                        r_state <= S_AG_E;
                    end else begin
                        r_j <= rd_col[gcn_pkg::NodeW-1:0];
                        r_state <= S_AG_NB;
                    end
                end
                S_AG_NB: begin
                    if (r_q >= fi_eff) begin
                        r_state <= S_AG_E;
                    end else begin
                        r_state <= S_AG_NB2;
                    end
                end
                S_AG_NB2: begin
                    r_agg[qq] <= gcn_pkg::sadd(r_agg[qq], rd_scd);
                    r_q <= r_q + 1'b1;
                    r_state <= S_AG_NB;
                end
                S_PJ_K: begin
                    if (r_o >= fo_eff) begin
                        r_state <= S_NEXT;
                    end else if (r_q >= fi_eff) begin
                        r_state <= S_PJ_S;
                    end else begin
                        r_state <= S_PJ_K2;
                    end
                end
                S_PJ_K2: begin
                    r_ma <= r_agg[qq];
                    r_mb <= rd_wt;
                    r_state <= S_PJ_M;
                end
                S_PJ_M: r_state <= S_PJ_ACC;
                S_PJ_ACC: begin
                    r_acc <= gcn_pkg::sadd(r_acc, mq);
                    r_q <= r_q + 1'b1;
                    r_state <= S_PJ_K;
                end
                S_PJ_S: begin
                    r_ma <= rd_scale;
                    r_mb <= r_acc;
                    r_state <= S_PJ_S2;
                end
                S_PJ_S2: r_state <= S_PJ_B;
                S_PJ_B: begin
                    r_acc <= '0;
                    r_state <= S_PJ_K;
                    r_o <= r_o + 1'b1;
                    r_q <= '0;
                end
                S_NEXT: begin
                    r_i <= r_i + 1'b1;
                    r_state <= S_AG_RS;
                end
                S_DONE: begin
                    r_ores   <= 32'sd0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/gcn_mac.sv =====
// Registered Q16.16 multiplier: one product per cycle, rounded result in the cycle after the operands.
// Depends on gcn_pkg.
module gcn_mac (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_q
);
    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_q = gcn_pkg::qround(r_prod);
endmodule

// ===== design/gcn_checker.sv =====
// Port checker for the graph-convolution layer, bound to the top level.
// Depends on the top level's ports only.
module gcn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_status,
    input logic [31:0] o_value_res
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value_res) && $stable(o_status))
        else $error("result beat changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result waits");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind gcn_layer_forward_csr gcn_checker u_gcn_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_value_res(o_value_res)
);
